// ----- rtl/nhp_pkg.sv -----
// Shared types, constants and section-skipping function of the network header parser.
`timescale 1ns / 1ps

package nhp_pkg;

	// Address bytes kept per address field; further bytes are only counted.
	localparam int unsigned ADDR_BYTES = 8;
	localparam int unsigned LANE_W     = 3;

	localparam logic [7:0] CTL_MSG = 8'h80;
	localparam logic [7:0] CTL_DST = 8'h20;
	localparam logic [7:0] CTL_SRC = 8'h08;
	localparam logic [7:0] MT_VENDOR = 8'h80;

	typedef enum logic [3:0] {
		PH_IDLE,
		PH_CTRL,
		PH_DNH,
		PH_DNL,
		PH_DLEN,
		PH_DADR,
		PH_SNH,
		PH_SNL,
		PH_SLEN,
		PH_SADR,
		PH_HOP,
		PH_MT,
		PH_VH,
		PH_VL,
		PH_DONE
	} nhp_phase_t;

	typedef struct packed {
		logic [7:0]  version;
		logic [7:0]  control;
		logic [15:0] dest_net;
		logic [7:0]  dest_len;
		logic [63:0] dest_addr;
		logic [15:0] src_net;
		logic [7:0]  src_len;
		logic [63:0] src_addr;
		logic [7:0]  hop_count;
		logic [7:0]  msg_type;
		logic [15:0] vendor_id;
		logic [9:0]  header_length;
	} nhp_result_t;

	// Skips the optional sections whose flag is clear, in header order.
	function automatic nhp_phase_t pick(nhp_phase_t from, logic [7:0] ctl);
		nhp_phase_t p;
		p = from;
		if (p == PH_DNH && (ctl & CTL_DST) == 8'h00) p = PH_SNH;
		if (p == PH_SNH && (ctl & CTL_SRC) == 8'h00) p = PH_HOP;
		if (p == PH_HOP && (ctl & CTL_DST) == 8'h00) p = PH_MT;
		if (p == PH_MT && (ctl & CTL_MSG) == 8'h00) p = PH_DONE;
		return p;
	endfunction

endpackage

// ----- rtl/nhp_parser.sv -----
// Header field registers and the per-item parse step of the network header parser.
`timescale 1ns / 1ps

module nhp_parser (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  logic [7:0]          data_byte,
	input  logic                frame_start,
	output logic                done,
	output nhp_pkg::nhp_result_t res
);
	import nhp_pkg::*;

	nhp_phase_t  phase_q, phase_nxt;
	logic [7:0]  cnt_q, cnt_nxt, cnt_inc;
	nhp_result_t fld_q, fld_nxt;
	logic [63:0] lane_val;
	logic        lane_ok;

	assign cnt_inc  = cnt_q + 8'd1;
	assign lane_ok  = cnt_q < 8'(ADDR_BYTES);
	assign lane_val = {56'd0, data_byte} << {cnt_q[LANE_W-1:0], 3'b000};

	always_comb begin
		fld_nxt   = fld_q;
		cnt_nxt   = cnt_q;
		phase_nxt = phase_q;
		done      = 1'b0;
		if (frame_start) begin
			fld_nxt               = '0;
			fld_nxt.version       = data_byte;
			fld_nxt.header_length = 10'd1;
			cnt_nxt               = 8'd0;
			phase_nxt             = PH_CTRL;
		end else if (phase_q == PH_IDLE || phase_q == PH_DONE) begin
			phase_nxt = PH_IDLE;
		end else begin
			fld_nxt.header_length = fld_q.header_length + 10'd1;
			case (phase_q)
				PH_CTRL: begin
					fld_nxt.control = data_byte;
					phase_nxt = pick(PH_DNH, data_byte);
				end
				PH_DNH: begin
					fld_nxt.dest_net = {data_byte, 8'h00};
					phase_nxt = PH_DNL;
				end
				PH_DNL: begin
					fld_nxt.dest_net = {fld_q.dest_net[15:8], data_byte};
					phase_nxt = PH_DLEN;
				end
				PH_DLEN: begin
					fld_nxt.dest_len = data_byte;
					cnt_nxt = 8'd0;
					phase_nxt = (data_byte != 8'd0) ? PH_DADR : pick(PH_SNH, fld_q.control);
				end
				PH_DADR: begin
					if (lane_ok) fld_nxt.dest_addr = fld_q.dest_addr | lane_val;
					cnt_nxt = cnt_inc;
					if (cnt_inc >= fld_q.dest_len) phase_nxt = pick(PH_SNH, fld_q.control);
				end
				PH_SNH: begin
					fld_nxt.src_net = {data_byte, 8'h00};
					phase_nxt = PH_SNL;
				end
				PH_SNL: begin
					fld_nxt.src_net = {fld_q.src_net[15:8], data_byte};
					phase_nxt = PH_SLEN;
				end
				PH_SLEN: begin
					fld_nxt.src_len = data_byte;
					cnt_nxt = 8'd0;
					phase_nxt = (data_byte != 8'd0) ? PH_SADR : pick(PH_HOP, fld_q.control);
				end
				PH_SADR: begin
					if (lane_ok) fld_nxt.src_addr = fld_q.src_addr | lane_val;
					cnt_nxt = cnt_inc;
					if (cnt_inc >= fld_q.src_len) phase_nxt = pick(PH_HOP, fld_q.control);
				end
				PH_HOP: begin
					fld_nxt.hop_count = data_byte;
					phase_nxt = pick(PH_MT, fld_q.control);
				end
				PH_MT: begin
					fld_nxt.msg_type = data_byte;
					phase_nxt = ((data_byte & MT_VENDOR) != 8'h00) ? PH_VH : PH_DONE;
				end
				PH_VH: begin
					fld_nxt.vendor_id = {data_byte, 8'h00};
					phase_nxt = PH_VL;
				end
				PH_VL: begin
					fld_nxt.vendor_id = {fld_q.vendor_id[15:8], data_byte};
					phase_nxt = PH_DONE;
				end
				default: begin
					phase_nxt = PH_IDLE;
				end
			endcase
			// The header ends on this item: report it and go back to idle.
			if (phase_nxt == PH_DONE) begin
				done      = 1'b1;
				phase_nxt = PH_IDLE;
			end
		end
	end

	assign res = fld_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			cnt_q   <= 8'd0;
			// Every field clears; the header length, in the lowest bits, starts at two.
			fld_q   <= {{($bits(nhp_result_t) - 10){1'b0}}, 10'd2};
		end else if (step) begin
			phase_q <= phase_nxt;
			cnt_q   <= cnt_nxt;
			fld_q   <= fld_nxt;
		end
	end

endmodule

// ----- rtl/npdu_header_parser_unit.sv -----
// Top level of the byte-serial network layer header parser.
//
// Usage: frame bytes enter on the byte channel (byte_valid, byte_stall,
// data_byte, frame_start); frame_start marks the version octet and restarts
// any header in progress without a result. When the last header byte has
// been parsed, one item appears on the result channel (result_valid,
// result_stall) carrying every header field and the header length, address
// bytes beyond the stored eight included. Bytes outside a header give
// nothing.
// Each accepted byte is held in an input register and parsed from there;
// when the last byte of a header is parsed, the result is loaded into the
// output register, where it can be taken. One byte is taken every
// cycle, limited only by the output register: while a result waits under
// result_stall, bytes that end no header still flow, and a byte that would
// end another header is held with byte_stall raised until the waiting
// result is taken.
// Reset clears the parse state, the input register's valid flag and the
// result valid flag; the block then waits for a frame_start byte.
`timescale 1ns / 1ps

module npdu_header_parser_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        byte_valid,
	output logic        byte_stall,
	input  logic [7:0]  data_byte,
	input  logic        frame_start,
	output logic        result_valid,
	input  logic        result_stall,
	output logic [7:0]  version,
	output logic [7:0]  control,
	output logic [15:0] dest_net,
	output logic [7:0]  dest_len,
	output logic [63:0] dest_addr,
	output logic [15:0] src_net,
	output logic [7:0]  src_len,
	output logic [63:0] src_addr,
	output logic [7:0]  hop_count,
	output logic [7:0]  msg_type,
	output logic [15:0] vendor_id,
	output logic [9:0]  header_length
);
	import nhp_pkg::*;

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        start_s1;
	logic        result_valid_q;
	nhp_result_t result_q;
	nhp_result_t res;
	logic        done;
	logic        out_free;
	logic        advance;
	logic        accept;

	assign out_free   = !result_valid_q || !result_stall;
	assign advance    = valid_s1 && (!done || out_free);
	assign byte_stall = valid_s1 && !advance;
	assign accept     = byte_valid && !byte_stall;

	nhp_parser u_parser (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (advance),
		.data_byte   (byte_s1),
		.frame_start (start_s1),
		.done        (done),
		.res         (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1  <= data_byte;
			start_s1 <= frame_start;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance && done) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && done) begin
			result_q <= res;
		end
	end

	assign result_valid  = result_valid_q;
	assign version       = result_q.version;
	assign control       = result_q.control;
	assign dest_net      = result_q.dest_net;
	assign dest_len      = result_q.dest_len;
	assign dest_addr     = result_q.dest_addr;
	assign src_net       = result_q.src_net;
	assign src_len       = result_q.src_len;
	assign src_addr      = result_q.src_addr;
	assign hop_count     = result_q.hop_count;
	assign msg_type      = result_q.msg_type;
	assign vendor_id     = result_q.vendor_id;
	assign header_length = result_q.header_length;

	// A result is never loaded over one that is still waiting.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		advance && done |-> out_free)
		else $error("result register overwritten while stalled");

	// A held byte stays in the input register until it is parsed.
	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		byte_stall |=> valid_s1 && $stable(byte_s1) && $stable(start_s1))
		else $error("held byte lost from input register");

	// Every header holds at least the version and control bytes.
	a_min_len: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q |-> header_length >= 10'd2)
		else $error("header length below two");

	// A new result appears only when a parsed byte ended a header.
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid_q) |-> $past(advance && done))
		else $error("result without an ending byte");

endmodule
